### rtl/core/fjot_pkg.sv
// Shared types, constants and helper functions for the flat JSON object tokenizer.
// Depends on nothing; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package fjot_pkg;

   // Queue between the classifier and the parser; depth must be a power of two.
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = QueuePtrW + 1;

   // Character codes the parser looks for.
   localparam logic [7:0] ChSpace  = 8'h20;
   localparam logic [7:0] ChTab    = 8'h09;
   localparam logic [7:0] ChLf     = 8'h0A;
   localparam logic [7:0] ChCr     = 8'h0D;
   localparam logic [7:0] ChLBrace = 8'h7B;
   localparam logic [7:0] ChRBrace = 8'h7D;
   localparam logic [7:0] ChColon  = 8'h3A;
   localparam logic [7:0] ChComma  = 8'h2C;
   localparam logic [7:0] ChQuote  = 8'h22;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChMinus  = 8'h2D;
   localparam logic [7:0] ChPlus   = 8'h2B;
   localparam logic [7:0] ChDot    = 8'h2E;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChNine   = 8'h39;
   localparam logic [7:0] ChLowE   = 8'h65;
   localparam logic [7:0] ChUpE    = 8'h45;
   localparam logic [7:0] ChLowT   = 8'h74;
   localparam logic [7:0] ChLowF   = 8'h66;
   localparam logic [7:0] ChLowN   = 8'h6E;
   localparam logic [7:0] ChLowR   = 8'h72;
   localparam logic [7:0] ChLowU   = 8'h75;
   localparam logic [7:0] ChLowL   = 8'h6C;
   localparam logic [7:0] ChLowS   = 8'h73;
   localparam logic [7:0] ChLowA   = 8'h61;

   // Output codes.
   localparam logic [1:0] KindNone  = 2'd0;
   localparam logic [1:0] KindKey   = 2'd1;
   localparam logic [1:0] KindValue = 2'd2;

   localparam logic [1:0] StatParsing  = 2'd0;
   localparam logic [1:0] StatClosed   = 2'd1;
   localparam logic [1:0] StatFailed   = 2'd2;
   localparam logic [1:0] StatUnclosed = 2'd3;

   // Literal kinds.
   localparam logic [1:0] LitTrue  = 2'd0;
   localparam logic [1:0] LitFalse = 2'd1;
   localparam logic [1:0] LitNull  = 2'd2;

   typedef struct packed {
      logic is_ws;
      logic is_num;       // any of -.0-9eE+
      logic is_num_start; // '-' or a digit
      logic is_lit_start; // 't', 'f' or 'n'
      logic is_quote;
      logic is_bslash;
      logic is_lbrace;
      logic is_rbrace;
      logic is_colon;
      logic is_comma;
   } byte_class_type;

   typedef struct packed {
      byte_class_type cls;
      logic [7:0]     data;
      logic           last;
   } item_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   typedef enum logic [12:0] {
      PH_OPEN      = 13'b0000000000001,
      PH_AWAIT_KEY = 13'b0000000000010,
      PH_KEY       = 13'b0000000000100,
      PH_KEY_ESC   = 13'b0000000001000,
      PH_AFTER_KEY = 13'b0000000010000,
      PH_BEFORE_V  = 13'b0000000100000,
      PH_STR       = 13'b0000001000000,
      PH_STR_ESC   = 13'b0000010000000,
      PH_NUM       = 13'b0000100000000,
      PH_LIT       = 13'b0001000000000,
      PH_AFTER_V   = 13'b0010000000000,
      PH_CLOSED    = 13'b0100000000000,
      PH_FAILED    = 13'b1000000000000
   } phase_type;

   // Number of characters in each literal.
   function automatic logic [2:0] lit_len(input logic [1:0] kind);
      logic [2:0] len;
      case (kind)
         LitFalse: len = 3'd5;
         default:  len = 3'd4;
      endcase
      return len;
   endfunction

   // Expected character at a given position of a literal.
   function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (kind)
         LitTrue: begin
            case (idx)
               3'd0:    c = ChLowT;
               3'd1:    c = ChLowR;
               3'd2:    c = ChLowU;
               3'd3:    c = ChLowE;
               default: c = 8'h00;
            endcase
         end
         LitFalse: begin
            case (idx)
               3'd0:    c = ChLowF;
               3'd1:    c = ChLowA;
               3'd2:    c = ChLowL;
               3'd3:    c = ChLowS;
               3'd4:    c = ChLowE;
               default: c = 8'h00;
            endcase
         end
         LitNull: begin
            case (idx)
               3'd0:    c = ChLowN;
               3'd1:    c = ChLowU;
               3'd2:    c = ChLowL;
               3'd3:    c = ChLowL;
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] decode_escape(input logic [7:0] c);
      logic [7:0] d;
      case (c)
         ChLowN:  d = ChLf;
         ChLowR:  d = ChCr;
         ChLowT:  d = ChTab;
         default: d = c;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

### rtl/core/fjot_front.sv
// Front end of the tokenizer: sorts each incoming byte into character classes.
// Depends on fjot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fjot_front (
   input  wire logic           [7:0] in_byte,
   input  wire logic                 last_byte,
   output fjot_pkg::item_type        item
);

   fjot_pkg::byte_class_type cls;
   logic is_digit;

   always_comb begin
      is_digit         = (in_byte >= fjot_pkg::ChZero) && (in_byte <= fjot_pkg::ChNine);
      cls.is_ws        = (in_byte == fjot_pkg::ChSpace) || (in_byte == fjot_pkg::ChTab) ||
                         (in_byte == fjot_pkg::ChLf) || (in_byte == fjot_pkg::ChCr);
      cls.is_num_start = is_digit || (in_byte == fjot_pkg::ChMinus);
      cls.is_num       = cls.is_num_start || (in_byte == fjot_pkg::ChDot) ||
                         (in_byte == fjot_pkg::ChLowE) || (in_byte == fjot_pkg::ChUpE) ||
                         (in_byte == fjot_pkg::ChPlus);
      cls.is_lit_start = (in_byte == fjot_pkg::ChLowT) || (in_byte == fjot_pkg::ChLowF) ||
                         (in_byte == fjot_pkg::ChLowN);
      cls.is_quote     = (in_byte == fjot_pkg::ChQuote);
      cls.is_bslash    = (in_byte == fjot_pkg::ChBslash);
      cls.is_lbrace    = (in_byte == fjot_pkg::ChLBrace);
      cls.is_rbrace    = (in_byte == fjot_pkg::ChRBrace);
      cls.is_colon     = (in_byte == fjot_pkg::ChColon);
      cls.is_comma     = (in_byte == fjot_pkg::ChComma);
   end

   assign item.cls  = cls;
   assign item.data = in_byte;
   assign item.last = last_byte;

endmodule

`default_nettype wire

### rtl/core/fjot_queue.sv
// Short first-in first-out queue of classified bytes between front and back.
// Depends on fjot_pkg for the item type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module fjot_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire fjot_pkg::item_type         push_item,
   input  wire logic                       pop,
   output fjot_pkg::item_type              head_item,
   output fjot_pkg::queue_status_type      status
);

   fjot_pkg::item_type                      slot_ff [fjot_pkg::QueueDepth];
   logic [fjot_pkg::QueuePtrW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [fjot_pkg::QueuePtrW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [fjot_pkg::QueueCntW-1:0]          count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item        = slot_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == fjot_pkg::QueueCntW'(fjot_pkg::QueueDepth));

endmodule

`default_nettype wire

### rtl/core/fjot_back.sv
// Back end of the tokenizer: the parse state machine and the result register.
// Depends on fjot_pkg for the phase encoding, codes and literal tables.
`timescale 1ns / 1ps
`default_nettype none

module fjot_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire fjot_pkg::item_type         head_item,
   input  wire fjot_pkg::queue_status_type queue_status,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                      [1:0] rsp_char_kind,
   output logic                      [7:0] rsp_out_char,
   output logic                            rsp_pair_complete,
   output logic                      [1:0] rsp_parse_status
);

   fjot_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          lit_kind_ff, lit_kind_in;
   logic [2:0]          lit_idx_ff, lit_idx_in;

   logic                valid_ff, valid_in;
   logic [1:0]          kind_ff, kind_in;
   logic [7:0]          char_ff, char_in;
   logic                done_ff, done_in;
   logic [1:0]          status_ff, status_in;

   fjot_pkg::phase_type ph;
   fjot_pkg::byte_class_type cls;
   logic [7:0]          c;
   logic                last;
   logic [2:0]          idx_next;

   // Take the head of the queue whenever the result register is free or drains now.
   assign pop = queue_status.not_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      cls         = head_item.cls;
      c           = head_item.data;
      last        = head_item.last;
      ph          = phase_ff;
      lit_kind_in = lit_kind_ff;
      lit_idx_in  = lit_idx_ff;
      kind_in     = fjot_pkg::KindNone;
      char_in     = 8'h00;
      done_in     = 1'b0;
      idx_next    = lit_idx_ff + 3'd1;

      // A number ends on its first non-number byte, which is then parsed as
      // the byte after a value.
      if (phase_ff == fjot_pkg::PH_NUM && !cls.is_num) begin
         done_in = 1'b1;
         ph      = fjot_pkg::PH_AFTER_V;
      end

      phase_in = ph;
      case (ph)
         fjot_pkg::PH_OPEN: begin
            if (cls.is_lbrace) begin
               phase_in = fjot_pkg::PH_AWAIT_KEY;
            end else if (!cls.is_ws) begin
               phase_in = fjot_pkg::PH_FAILED;
            end
         end
         fjot_pkg::PH_AFTER_V, fjot_pkg::PH_AWAIT_KEY: begin
            if (!cls.is_ws) begin
               if (ph == fjot_pkg::PH_AFTER_V && cls.is_comma) begin
                  phase_in = fjot_pkg::PH_AWAIT_KEY;
               end else if (cls.is_rbrace) begin
                  phase_in = fjot_pkg::PH_CLOSED;
               end else if (cls.is_quote) begin
                  phase_in = fjot_pkg::PH_KEY;
               end else begin
                  phase_in = fjot_pkg::PH_FAILED;
               end
            end
         end
         fjot_pkg::PH_KEY, fjot_pkg::PH_STR: begin
            if (cls.is_quote) begin
               if (ph == fjot_pkg::PH_STR) begin
                  done_in  = 1'b1;
                  phase_in = fjot_pkg::PH_AFTER_V;
               end else begin
                  phase_in = fjot_pkg::PH_AFTER_KEY;
               end
            end else if (cls.is_bslash && !last) begin
               phase_in = (ph == fjot_pkg::PH_KEY) ? fjot_pkg::PH_KEY_ESC
                                                   : fjot_pkg::PH_STR_ESC;
            end else begin
               kind_in = (ph == fjot_pkg::PH_KEY) ? fjot_pkg::KindKey : fjot_pkg::KindValue;
               char_in = c;
            end
         end
         fjot_pkg::PH_KEY_ESC, fjot_pkg::PH_STR_ESC: begin
            kind_in  = (ph == fjot_pkg::PH_KEY_ESC) ? fjot_pkg::KindKey : fjot_pkg::KindValue;
            char_in  = fjot_pkg::decode_escape(c);
            phase_in = (ph == fjot_pkg::PH_KEY_ESC) ? fjot_pkg::PH_KEY : fjot_pkg::PH_STR;
         end
         fjot_pkg::PH_AFTER_KEY: begin
            if (cls.is_colon) begin
               phase_in = fjot_pkg::PH_BEFORE_V;
            end else if (!cls.is_ws) begin
               phase_in = fjot_pkg::PH_FAILED;
            end
         end
         fjot_pkg::PH_BEFORE_V: begin
            if (!cls.is_ws) begin
               if (cls.is_quote) begin
                  phase_in = fjot_pkg::PH_STR;
               end else if (cls.is_num_start) begin
                  phase_in = fjot_pkg::PH_NUM;
                  kind_in  = fjot_pkg::KindValue;
                  char_in  = c;
               end else if (cls.is_lit_start) begin
                  if (c == fjot_pkg::ChLowT) begin
                     lit_kind_in = fjot_pkg::LitTrue;
                  end else if (c == fjot_pkg::ChLowF) begin
                     lit_kind_in = fjot_pkg::LitFalse;
                  end else begin
                     lit_kind_in = fjot_pkg::LitNull;
                  end
                  lit_idx_in = 3'd1;
                  phase_in   = fjot_pkg::PH_LIT;
                  kind_in    = fjot_pkg::KindValue;
                  char_in    = c;
               end else begin
                  phase_in = fjot_pkg::PH_FAILED;
               end
            end
         end
         fjot_pkg::PH_NUM: begin
            kind_in = fjot_pkg::KindValue;
            char_in = c;
         end
         fjot_pkg::PH_LIT: begin
            if (lit_kind_ff != 2'd3 && lit_idx_ff < fjot_pkg::lit_len(lit_kind_ff) &&
                fjot_pkg::lit_char(lit_kind_ff, lit_idx_ff) == c) begin
               kind_in    = fjot_pkg::KindValue;
               char_in    = c;
               lit_idx_in = idx_next;
               if (idx_next >= fjot_pkg::lit_len(lit_kind_ff)) begin
                  done_in  = 1'b1;
                  phase_in = fjot_pkg::PH_AFTER_V;
               end
            end else begin
               phase_in = fjot_pkg::PH_FAILED;
            end
         end
         fjot_pkg::PH_CLOSED: begin
            phase_in = fjot_pkg::PH_CLOSED;
         end
         default: begin
            phase_in = fjot_pkg::PH_FAILED;
         end
      endcase

      // A number still open at the last byte ends there.
      if (last && phase_in == fjot_pkg::PH_NUM) begin
         done_in = 1'b1;
      end

      if (phase_in == fjot_pkg::PH_CLOSED) begin
         status_in = fjot_pkg::StatClosed;
      end else if (phase_in == fjot_pkg::PH_FAILED) begin
         status_in = fjot_pkg::StatFailed;
      end else begin
         status_in = last ? fjot_pkg::StatUnclosed : fjot_pkg::StatParsing;
      end

      // The parser starts over after the last byte of a message.
      if (last) begin
         phase_in    = fjot_pkg::PH_OPEN;
         lit_kind_in = fjot_pkg::LitTrue;
         lit_idx_in  = 3'd0;
      end

      valid_in = pop ? 1'b1 : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= fjot_pkg::PH_OPEN;
         lit_kind_ff <= fjot_pkg::LitTrue;
         lit_idx_ff  <= 3'd0;
         valid_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            phase_ff    <= phase_in;
            lit_kind_ff <= lit_kind_in;
            lit_idx_ff  <= lit_idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= kind_in;
         char_ff   <= char_in;
         done_ff   <= done_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_char_kind     = kind_ff;
   assign rsp_out_char      = char_ff;
   assign rsp_pair_complete = done_ff;
   assign rsp_parse_status  = status_ff;

endmodule

`default_nettype wire

### rtl/core/flat_json_object_tokenizer_unit.sv
// Top level of the flat JSON object tokenizer.
// Depends on fjot_pkg, fjot_front, fjot_queue and fjot_back.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one message byte per transfer and returns exactly one result
// transfer per byte: the decoded key or value character (if any), a flag that
// marks the end of a kept key/value pair, and the parse status. Bytes are
// classified on arrival and written into a four-entry queue; the parser
// behind it reads one byte per cycle unless the result side stalls, and writes
// its result into an output register. With no back-pressure a byte is taken
// every cycle. A byte is registered first in the queue and then in the output
// register, and its result is driven on the rsp_ ports from the output
// register. The queue lets the input keep flowing for up to four bytes while the
// result side stalls; req_stall rises only when the queue is full. The parse
// state loop is closed once per popped byte by the parser.
module flat_json_object_tokenizer_unit (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_last_byte,

   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [1:0] rsp_char_kind,
   output logic      [7:0] rsp_out_char,
   output logic            rsp_pair_complete,
   output logic      [1:0] rsp_parse_status
);

   fjot_pkg::item_type         front_item;
   fjot_pkg::item_type         head_item;
   fjot_pkg::queue_status_type queue_status;
   logic                       push;
   logic                       pop;

   // A byte transfer happens whenever the queue has room.
   assign req_stall = queue_status.full;
   assign push      = req_valid && !req_stall;

   fjot_front u_front (
      .in_byte   (req_in_byte),
      .last_byte (req_last_byte),
      .item      (front_item)
   );

   fjot_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (queue_status)
   );

   fjot_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_item         (head_item),
      .queue_status      (queue_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_kind     (rsp_char_kind),
      .rsp_out_char      (rsp_out_char),
      .rsp_pair_complete (rsp_pair_complete),
      .rsp_parse_status  (rsp_parse_status)
   );

   // The parser never reads an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_status.not_empty)
      else $error("parser popped an empty queue");

   // A character is only emitted while the parse status is parsing or unclosed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_kind != fjot_pkg::KindNone) |->
      (rsp_parse_status == fjot_pkg::StatParsing ||
       rsp_parse_status == fjot_pkg::StatUnclosed))
      else $error("character emitted after parsing stopped");

   // A pair always ends on a value, never on a key character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pair_complete) |-> (rsp_char_kind != fjot_pkg::KindKey))
      else $error("pair completed on a key character");

   // The result of a popped byte is visible in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped byte produced no result");

endmodule

`default_nettype wire
